// ===== hw/rtl/sps_pkg.sv =====
// sps_pkg: shared types and constants for the support-point search block
// payload structs, vertex and cell packet types, op and register codes
// no dependencies
package sps_pkg;

  // default store depth
  localparam int SPS_MAX_VERTICES = 1024;

  // exact three-term dot product of q8.8 values fits in 33 signed bits
  localparam int DOT_W = 33;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_OFFSET_Z = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               store_empty;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vertex_t;

  // packet handed from one dot-product cell to the next
  typedef struct packed {
    logic                    vld;
    vertex_t                 vtx;
    logic signed [DOT_W-1:0] psum;
  } cell_pkt_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/sps_dot_cell.sv =====
// sps_dot_cell: one cell of the dot-product chain, handles one axis
// multiplies its coordinate by the direction and adds to the partial sum
// depends on sps_pkg
module sps_dot_cell
  import sps_pkg::*;
#(
  parameter int AXIS = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  vertex_t   dir,
  input  cell_pkt_t pkt_i,
  output cell_pkt_t pkt_o,
  output logic      busy
);

  logic signed [15:0] vc;
  logic signed [15:0] dc;
  logic signed [31:0] prod_nxt;

  logic                    a_vld_r;
  vertex_t                 a_vtx_r;
  logic signed [DOT_W-1:0] a_psum_r;
  logic signed [31:0]      a_prod_r;

  logic                    b_vld_r;
  vertex_t                 b_vtx_r;
  logic signed [DOT_W-1:0] b_psum_r;
  logic signed [DOT_W-1:0] b_psum_nxt;

  // pick this cell's axis
  always_comb begin
    case (AXIS)
      0: begin
        vc = pkt_i.vtx.x;
        dc = dir.x;
      end
      1: begin
        vc = pkt_i.vtx.y;
        dc = dir.y;
      end
      default: begin
        vc = pkt_i.vtx.z;
        dc = dir.z;
      end
    endcase
  end

  assign prod_nxt = vc * dc;

  // first stage: product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= pkt_i.vld;
    end
    a_vtx_r  <= pkt_i.vtx;
    a_psum_r <= pkt_i.psum;
    a_prod_r <= prod_nxt;
  end

  // second stage: accumulate into the partial sum
  assign b_psum_nxt = a_psum_r + $signed({{(DOT_W-32){a_prod_r[31]}}, a_prod_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_vtx_r  <= a_vtx_r;
    b_psum_r <= b_psum_nxt;
  end

  assign pkt_o.vld  = b_vld_r;
  assign pkt_o.vtx  = b_vtx_r;
  assign pkt_o.psum = b_psum_r;
  assign busy       = a_vld_r | b_vld_r;

endmodule

// ===== hw/rtl/sps_argmax.sv =====
// sps_argmax: running maximum over the dot products leaving the cell chain
// keeps the earliest vertex on ties
// depends on sps_pkg
module sps_argmax
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  cell_pkt_t pkt_i,
  output logic      have,
  output vertex_t   best_vtx
);

  logic                    have_r;
  logic signed [DOT_W-1:0] best_dot_r;
  vertex_t                 best_vtx_r;
  logic                    take;

  // strictly greater replaces, so the first of equals stays
  assign take = pkt_i.vld && (!have_r || (pkt_i.psum > best_dot_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (start) begin
      have_r <= 1'b0;
    end else if (pkt_i.vld) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dot_r <= pkt_i.psum;
      best_vtx_r <= pkt_i.vtx;
    end
  end

  assign have     = have_r;
  assign best_vtx = best_vtx_r;

endmodule

// ===== hw/rtl/support_point_search.sv =====
// support_point_search: a query is answered after transfer by a scan of the count stored vertices
// through the store reads, six dot-product cell stages, one running-maximum update, the drain
// state that sees the chain empty and one output stage; an empty store skips the scan.
// input is taken again once the result is registered, which waits until an earlier
// result has left the output register; clear and load leave the block ready for the next item.
// synchronous active-low reset empties the store and zeroes the offsets; contents are kept.
module support_point_search
  import sps_pkg::*;
#(
  parameter int MAX_VERTICES = SPS_MAX_VERTICES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r;
  logic [AW-1:0] rd_addr_r;
  logic          rd_vld_r;
  vertex_t       rd_data_r;
  vertex_t       dir_r;
  vertex_t       mem [MAX_VERTICES];

  logic signed [15:0] off_x_r, off_y_r, off_z_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic in_acc, is_query, is_load, is_clear;
  logic last, store_full, out_free, inflight;
  logic scan_en, done_load;

  cell_pkt_t chain [4];
  logic [2:0] cell_busy;

  logic    have;
  vertex_t best_vtx;
  vertex_t sel_vtx;

  assign in_acc     = in_valid && in_ready;
  assign is_query   = (in_data.op == OP_QUERY);
  assign is_load    = (in_data.op == OP_LOAD);
  assign is_clear   = (in_data.op == OP_CLEAR);
  assign store_full = (count_r == CW'(MAX_VERTICES));
  assign last       = (CW'(rd_addr_r) == (count_r - CW'(1)));
  assign out_free   = !out_valid_r || out_ready;
  assign inflight   = rd_vld_r || (|cell_busy);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = (count_r == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!inflight) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    scan_en   = 1'b0;
    done_load = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_SCAN:  scan_en   = 1'b1;
      S_DRAIN: ;
      S_DONE:  done_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OFFSET_X: off_x_r <= cfg_wdata;
        CFG_OFFSET_Y: off_y_r <= cfg_wdata;
        CFG_OFFSET_Z: off_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && is_clear) begin
      count_r <= '0;
    end else if (in_acc && is_load && !store_full) begin
      count_r <= count_r + CW'(1);
    end
  end

  // vertex store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && is_load && !store_full) begin
      mem[count_r[AW-1:0]] <= '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // scan address and read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= scan_en;
      if (in_acc && is_query) begin
        rd_addr_r <= '0;
      end else if (scan_en && !last) begin
        rd_addr_r <= rd_addr_r + AW'(1);
      end
    end
  end

  // query direction held for the whole scan
  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      dir_r <= '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
    end
  end

  // chain of dot-product cells, one per axis
  assign chain[0].vld  = rd_vld_r;
  assign chain[0].vtx  = rd_data_r;
  assign chain[0].psum = '0;

  for (genvar g = 0; g < 3; g++) begin : g_cell
    sps_dot_cell #(
      .AXIS (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .dir   (dir_r),
      .pkt_i (chain[g]),
      .pkt_o (chain[g+1]),
      .busy  (cell_busy[g])
    );
  end

  // running maximum
  sps_argmax u_argmax (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && is_query),
    .pkt_i    (chain[3]),
    .have     (have),
    .best_vtx (best_vtx)
  );

  // add offset with saturation
  function automatic logic signed [15:0] sat_add(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      sat_add = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  assign sel_vtx = have ? best_vtx : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data_r.point_x     <= sat_add(sel_vtx.x, off_x_r);
      out_data_r.point_y     <= sat_add(sel_vtx.y, off_y_r);
      out_data_r.point_z     <= sat_add(sel_vtx.z, off_z_r);
      out_data_r.store_empty <= !have;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/sps_checker.sv =====
// sps_checker: port-level checks on support_point_search over time
// bound to the top level; depends on sps_pkg
module sps_checker
  import sps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the block only goes busy after a query transfer
  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && (in_data.op == OP_QUERY)))
    else $error("input stalled without a query");

  // a fresh result is produced only while input is held off
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind support_point_search sps_checker u_sps_checker (.*);
